// File: rtl/bss_pkg.sv
package bss_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 6;
    localparam int ECNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_SRCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] popped_value;
        logic [FOUND_W-1:0]       found_index;
        logic signed [WORD_W-1:0] top_value;
        logic [ECNT_W-1:0]        entry_count;
    } rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// File: rtl/bss_mem.sv
module bss_mem (
    input  logic                      aclk,
    input  bss_pkg::mem_req_t         mem_req,
    output logic [bss_pkg::WORD_W-1:0] rd_data
);

    logic [bss_pkg::WORD_W-1:0] mem [bss_pkg::DEPTH];
    logic [bss_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bss_ctrl.sv
module bss_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  bss_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output bss_pkg::rsp_t              rsp,
    output bss_pkg::mem_req_t          mem_req,
    input  logic [bss_pkg::WORD_W-1:0] mem_rd_data
);

    bss_pkg::state_t             state_reg,  state_next;
    logic [bss_pkg::CNT_W-1:0]   count_reg,  count_next;
    logic [bss_pkg::WORD_W-1:0]  top_reg,    top_next;
    logic [bss_pkg::WORD_W-1:0]  key_reg,    key_next;
    logic [bss_pkg::ADDR_W-1:0]  idx_reg,    idx_next;
    bss_pkg::status_t            status_reg, status_next;
    logic [bss_pkg::WORD_W-1:0]  popped_reg, popped_next;
    logic [bss_pkg::ADDR_W-1:0]  found_reg,  found_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bss_pkg::S_IDLE;
            count_reg <= '0;
            top_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
        end
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        found_reg  <= found_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        found_next  = found_reg;
        mem_req     = '0;
        req_ready   = (state_reg == bss_pkg::S_IDLE);
        rsp_valid   = 1'b0;

        case (state_reg)
            bss_pkg::S_IDLE: begin
                if (req_valid) begin
                    status_next = bss_pkg::ST_OK;
                    popped_next = '0;
                    found_next  = '0;
                    state_next  = bss_pkg::S_DONE;
                    case (req.func)
                        bss_pkg::OP_PUSH: begin
                            if (count_reg == bss_pkg::CNT_W'(bss_pkg::DEPTH)) begin
                                status_next = bss_pkg::ST_OVERFLOW;
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = count_reg[bss_pkg::ADDR_W-1:0];
                                mem_req.wr_data = req.data_in;
                                top_next        = req.data_in;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        bss_pkg::OP_POP: begin
                            if (count_reg == '0) begin
                                status_next = bss_pkg::ST_EMPTY;
                            end else begin
                                popped_next = top_reg;
                                count_next  = count_reg - 1'b1;
                                if (count_reg == bss_pkg::CNT_W'(1)) begin
                                    top_next = '0;
                                end else begin
                                    // fetch the entry that becomes the new top
                                    mem_req.rd_en   = 1'b1;
                                    mem_req.rd_addr =
                                        bss_pkg::ADDR_W'(count_reg - bss_pkg::CNT_W'(2));
                                    state_next      = bss_pkg::S_POP_RD;
                                end
                            end
                        end
                        bss_pkg::OP_SEARCH: begin
                            key_next = req.data_in;
                            if (count_reg == '0) begin
                                status_next = bss_pkg::ST_NOTFOUND;
                            end else begin
                                idx_next        = bss_pkg::ADDR_W'(count_reg - 1'b1);
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = bss_pkg::ADDR_W'(count_reg - 1'b1);
                                state_next      = bss_pkg::S_SRCH;
                            end
                        end
                        default: begin
                            status_next = bss_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bss_pkg::S_POP_RD: begin
                top_next   = mem_rd_data;
                state_next = bss_pkg::S_DONE;
            end
            bss_pkg::S_SRCH: begin
                // compare the entry at idx_reg, fetch the one below meanwhile
                if (mem_rd_data == key_reg) begin
                    found_next  = idx_reg;
                    status_next = bss_pkg::ST_OK;
                    state_next  = bss_pkg::S_DONE;
                end else if (idx_reg == '0) begin
                    status_next = bss_pkg::ST_NOTFOUND;
                    state_next  = bss_pkg::S_DONE;
                end else begin
                    idx_next        = idx_reg - 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg - 1'b1;
                end
            end
            bss_pkg::S_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = bss_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        rsp.status       = status_reg;
        rsp.popped_value = popped_reg;
        rsp.found_index  = bss_pkg::FOUND_W'(found_reg);
        rsp.top_value    = top_reg;
        rsp.entry_count  = bss_pkg::ECNT_W'(count_reg);
    end

endmodule

// File: rtl/bounded_stack_with_search_core.sv
// Bounded LIFO stack of signed 32-bit words with a top-down search.
// Input channel (s_valid/s_ready/s_data): one request per item, a push,
// a pop or a search of s_data.data_in. Result channel (m_valid/m_ready/
// m_data): exactly one result per request, in request order, carrying the
// status, the popped value, the found index, the top entry and the count.
// The block handles one request at a time; s_ready is high only while the
// sequencer is idle, and it may take the next request while the previous
// result still sits in the output register.
// Path to m_valid: a push, a pop that leaves the stack empty, a pop or
// search of an empty stack and the unused code go straight to the result;
// other pops first do one memory read for the new top; a search examines
// entries from the top (one compare per cycle on the single memory read
// port) until a match or the bottom entry. The next request can be taken
// once the previous result has moved into the output register.
// Reset (aresetn low, synchronous) empties the stack and drops any
// pending result; memory contents are not cleared.
// When the receiver stalls, the result holds in the output register and
// the sequencer holds its next result until the register frees up.
module bounded_stack_with_search_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bss_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bss_pkg::rsp_t m_data
);

    bss_pkg::mem_req_t          mem_req;
    logic [bss_pkg::WORD_W-1:0] mem_rd_data;
    logic                       rsp_valid;
    logic                       out_free;
    bss_pkg::rsp_t              rsp;

    logic                       m_valid_reg;
    bss_pkg::rsp_t              m_data_reg;

    // Entry storage: one write and one registered read per cycle.
    bss_mem u_mem (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (mem_rd_data)
    );

    // Sequencer: owns the count and top registers and the shared compare.
    bss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (s_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (out_free),
        .rsp         (rsp),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // Output register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the payload alongside valid; hold it while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (rsp_valid && out_free) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: tb/sv/tb_bounded_stack_with_search_core.sv
module tb_bounded_stack_with_search_core;

    import bss_pkg::*;

    // The spare operation code has no member in op_t; the block treats it as a no-op.
    localparam logic [FUNC_W-1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_ITEMS   = 1250;
    localparam int LONG_HOLD      = 250;   // receiver hold-off that backs up the input side
    localparam int HOLD_AFTER     = 300;   // results to see before that hold-off starts
    localparam int DRAIN_CYCLES   = 120;   // covers a full-depth search plus slack
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] data;
        bit                typed;
        rsp_t              want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    bounded_stack_with_search_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the stack, advanced once per accepted request.
    logic [WORD_W-1:0] stack_mem [DEPTH];
    int                stack_cnt;

    rsp_t     rsp_due [$];     // results owed by the block, oldest first
    dir_row_t dir_rows [$];

    int n_sent, n_checked, mismatches, quiet_cycles;
    int n_push, n_pop, n_search, n_spare;
    int n_overflow, n_empty, n_miss, peak_depth;
    bit long_hold_done;
    int rx_gap;

    // Apply one request to the shadow stack and return the result it owes.
    function automatic rsp_t stack_apply(input req_t r);
        rsp_t o;
        int   i;
        bit   hit;
        o   = '0;
        hit = 1'b0;
        case (r.func)
            OP_PUSH: begin
                n_push++;
                if (stack_cnt >= DEPTH) begin
                    o.status = ST_OVERFLOW;
                    n_overflow++;
                end else begin
                    stack_mem[stack_cnt] = r.data_in;
                    stack_cnt++;
                end
            end
            OP_POP: begin
                n_pop++;
                if (stack_cnt == 0) begin
                    o.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    stack_cnt--;
                    o.popped_value = stack_mem[stack_cnt];
                end
            end
            OP_SEARCH: begin
                n_search++;
                // walk down from the top, first match wins
                for (i = stack_cnt - 1; i >= 0 && !hit; i--) begin
                    if (stack_mem[i] == r.data_in) begin
                        hit           = 1'b1;
                        o.found_index = FOUND_W'(i);
                    end
                end
                if (!hit) begin
                    o.status = ST_NOTFOUND;
                    n_miss++;
                end
            end
            default: n_spare++;
        endcase
        o.top_value   = (stack_cnt == 0) ? '0 : stack_mem[stack_cnt-1];
        o.entry_count = ECNT_W'(stack_cnt);
        if (stack_cnt > peak_depth) peak_depth = stack_cnt;
        return o;
    endfunction

    function automatic rsp_t mk_rsp(input status_t st, input logic [WORD_W-1:0] popped,
                                    input int found, input logic [WORD_W-1:0] top,
                                    input int cnt);
        rsp_t o;
        o.status       = st;
        o.popped_value = popped;
        o.found_index  = FOUND_W'(found);
        o.top_value    = top;
        o.entry_count  = ECNT_W'(cnt);
        return o;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Full-range words, a small pool that makes duplicates likely, and the extremes.
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 5) return $urandom;
        if (k < 8) return WORD_W'($urandom_range(0, 7)) - 32'd4;
        if (k == 8) return 32'h8000_0000;
        return 32'h7FFF_FFFF;
    endfunction

    function automatic req_t next_req(input mix_t mix);
        req_t        r;
        int unsigned roll, push_pct, pop_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_pct = 70; pop_pct = 12; end
            MIX_DRAIN: begin push_pct = 12; pop_pct = 70; end
            default:   begin push_pct = 40; pop_pct = 35; end
        endcase
        r.data_in = pick_word();
        if (roll < push_pct) begin
            r.func = OP_PUSH;
        end else if (roll < push_pct + pop_pct) begin
            r.func = OP_POP;
        end else if (roll < 97) begin
            r.func = OP_SEARCH;
            // search for a held value most of the time so hits land at every depth
            if (stack_cnt > 0 && $urandom_range(0, 9) < 6)
                r.data_in = stack_mem[$urandom_range(0, stack_cnt - 1)];
        end else begin
            r.func = OP_SPARE;
        end
        return r;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] d,
                           input bit typed, input rsp_t want);
        dir_row_t row;
        row.func  = f;
        row.data  = d;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Offer one request at the falling edge, hold it until taken, then idle a bit if a gap is drawn.
    task automatic offer(input req_t r, input bit typed, input rsp_t want);
        rsp_t pred;
        int   gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = stack_apply(r);
        rsp_due.push_back(typed ? want : pred);
        n_sent++;
        // every fourth stretch of 200 requests runs with no gaps
        gap = ((n_sent / 200) % 4 == 3) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Receiver: random stalls, a stall-free stretch now and then, and one long hold-off.
    initial begin
        m_ready = 1'b0;
        rx_gap  = 0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && n_checked >= HOLD_AFTER) begin
                // hold off long enough that the block backs up and drops s_ready
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
                if ((n_checked / 150) % 4 != 2) rx_gap = pick_gap();
            end
        end
    end

    // Compare each accepted result with the oldest owed one.
    rsp_t due;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rsp_due.size() == 0) begin
                $error("result with nothing owed: status %0d count %0d",
                       m_data.status, m_data.entry_count);
                mismatches++;
            end else begin
                due = rsp_due.pop_front();
                if (m_data.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, m_data.status);
                    mismatches++;
                end
                if (m_data.popped_value !== due.popped_value) begin
                    $error("popped_value: expected %0d, got %0d",
                           due.popped_value, m_data.popped_value);
                    mismatches++;
                end
                if (m_data.found_index !== due.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           due.found_index, m_data.found_index);
                    mismatches++;
                end
                if (m_data.top_value !== due.top_value) begin
                    $error("top_value: expected %0d, got %0d", due.top_value, m_data.top_value);
                    mismatches++;
                end
                if (m_data.entry_count !== due.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           due.entry_count, m_data.entry_count);
                    mismatches++;
                end
            end
            n_checked++;
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d results still owed", rsp_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        req_t r;
        mix_t mix;
        int   seg_len, n_random;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        stack_cnt = 0;
        n_random  = 0;

        // Directed requests: empty-stack cases, the word extremes, duplicates, spare code.
        add_row(OP_POP,    32'd0,         1, mk_rsp(ST_EMPTY,    0, 0, 0, 0));
        add_row(OP_SEARCH, 32'd0,         1, mk_rsp(ST_NOTFOUND, 0, 0, 0, 0));
        add_row(OP_SPARE,  32'hFFFF_FFFF, 1, mk_rsp(ST_OK,       0, 0, 0, 0));
        add_row(OP_PUSH,   32'h7FFF_FFFF, 1, mk_rsp(ST_OK, 0, 0, 32'h7FFF_FFFF, 1));
        add_row(OP_PUSH,   32'h8000_0000, 1, mk_rsp(ST_OK, 0, 0, 32'h8000_0000, 2));
        add_row(OP_PUSH,   32'd0,         1, mk_rsp(ST_OK, 0, 0, 32'd0, 3));
        add_row(OP_PUSH,   32'hFFFF_FFFF, 1, mk_rsp(ST_OK, 0, 0, 32'hFFFF_FFFF, 4));
        add_row(OP_SEARCH, 32'h7FFF_FFFF, 1, mk_rsp(ST_OK, 0, 0, 32'hFFFF_FFFF, 4));
        add_row(OP_SEARCH, 32'hFFFF_FFFF, 1, mk_rsp(ST_OK, 0, 3, 32'hFFFF_FFFF, 4));
        add_row(OP_SEARCH, 32'h8000_0000, 1, mk_rsp(ST_OK, 0, 1, 32'hFFFF_FFFF, 4));
        add_row(OP_SEARCH, 32'h0001_2345, 1, mk_rsp(ST_NOTFOUND, 0, 0, 32'hFFFF_FFFF, 4));
        add_row(OP_PUSH,   32'h7FFF_FFFF, 0, '0);
        add_row(OP_SEARCH, 32'h7FFF_FFFF, 0, '0);   // two copies: nearest the top wins
        add_row(OP_SPARE,  32'h5A5A_A5A5, 0, '0);
        add_row(OP_POP,    32'h1234_5678, 1, mk_rsp(ST_OK, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 4));
        add_row(OP_POP,    32'd0,         1, mk_rsp(ST_OK, 32'hFFFF_FFFF, 0, 32'd0, 3));
        add_row(OP_POP,    32'd0,         1, mk_rsp(ST_OK, 32'd0, 0, 32'h8000_0000, 2));
        add_row(OP_POP,    32'd0,         1, mk_rsp(ST_OK, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1));
        add_row(OP_POP,    32'd0,         1, mk_rsp(ST_OK, 32'h7FFF_FFFF, 0, 32'd0, 0));
        add_row(OP_POP,    32'hFFFF_FFFF, 1, mk_rsp(ST_EMPTY, 0, 0, 0, 0));

        // Hold reset low, then release it at a falling edge.
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k]) begin
            r.func    = dir_rows[k].func;
            r.data_in = dir_rows[k].data;
            offer(r, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random segments; open with a long fill so the stack overflows early.
        mix     = MIX_FILL;
        seg_len = 150;
        while (n_random < RANDOM_ITEMS) begin
            repeat (seg_len) begin
                offer(next_req(mix), 1'b0, '0);
                n_random++;
            end
            mix     = mix_t'($urandom_range(0, 2));
            seg_len = $urandom_range(30, 150);
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain the owed results, then linger for any stray one.
        wait (rsp_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests: %0d push, %0d pop, %0d search, %0d spare code; peak depth %0d",
                 n_sent, n_push, n_pop, n_search, n_spare, peak_depth);
        $display("Hit %0d overflows, %0d empty pops, %0d failed searches; %0d results checked",
                 n_overflow, n_empty, n_miss, n_checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
